// File: hw/rtl/ddwce_pkg.sv
// Shared types and constants of the differential-drive wheel command encoder.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package ddwce_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned SpeedW   = 24;
  localparam int unsigned LimW     = 23;
  localparam int unsigned GainW    = 24;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CharW    = 6;
  localparam int unsigned MulW     = 24;
  localparam int unsigned NumChars = 8;

  // Register reset values
  localparam logic [LimW-1:0]  LinearLimitRst   = 23'd13107;
  localparam logic [LimW-1:0]  AngularLimitRst  = 23'd98304;
  localparam logic [LimW-1:0]  HalfTrackRst     = 23'd6554;
  localparam logic [GainW-1:0] InvRadiusRst     = 24'd2016492;
  localparam logic [LimW-1:0]  WheelSpeedCapRst = 23'd655360;
  localparam logic [LimW-1:0]  LevelGainRst     = 23'd163840;
  localparam logic [TickW-1:0] TimeoutTicksRst  = 8'd20;

  // ASCII codes, truncated to the character width
  localparam logic [CharW-1:0] CharZero = 6'd48;
  localparam logic [CharW-1:0] CharFwd  = 6'd49;
  localparam logic [CharW-1:0] CharRev  = 6'd50;

  localparam logic [4:0] LevelCap = 5'd25;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINEAR_LIMIT    = 3'd0,
    CFG_ANGULAR_LIMIT   = 3'd1,
    CFG_HALF_TRACK      = 3'd2,
    CFG_INV_RADIUS      = 3'd3,
    CFG_WHEEL_SPEED_CAP = 3'd4,
    CFG_LEVEL_GAIN      = 3'd5,
    CFG_TIMEOUT_TICKS   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    KIND_VELOCITY = 1'b0,
    KIND_TICK     = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_TURN,
    B_TURN_FLOOR,
    B_SUM,
    B_MUL_LO,
    B_MUL_HI,
    B_ACC,
    B_CLAMP,
    B_LEVEL,
    B_DIGITS,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [LimW-1:0]  linear_limit;
    logic [LimW-1:0]  angular_limit;
    logic [LimW-1:0]  half_track;
    logic [GainW-1:0] inv_radius;
    logic [LimW-1:0]  wheel_speed_cap;
    logic [LimW-1:0]  level_gain;
    logic [TickW-1:0] timeout_ticks;
  } cfg_t;

  // One queued job: either a stop string or a velocity command
  typedef struct packed {
    logic                     stop;
    logic signed [SpeedW-1:0] lin;
    logic signed [SpeedW-1:0] ang;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ddwce_queue.sv
// Two-entry job queue between the front and the back of the encoder.
// Depends on ddwce_pkg.
`default_nettype none

module ddwce_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ddwce_pkg::entry_t   push_data_i,
  input  logic                pop_i,
  output ddwce_pkg::entry_t   head_o,
  output ddwce_pkg::q_status_t status_o
);
  import ddwce_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

// File: hw/rtl/ddwce_front.sv
// Front end: takes input transactions, keeps the idle tick counter and
// queues velocity jobs and stop strings. Depends on ddwce_pkg.
`default_nettype none

module ddwce_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [47:0]                     s_axis_tdata,  // linear_velocity, angular_velocity
  input  logic                            s_axis_tuser,  // kind
  input  logic [ddwce_pkg::TickW-1:0]     timeout_ticks_i,
  input  ddwce_pkg::q_status_t            q_status_i,
  output logic                            push_o,
  output ddwce_pkg::entry_t               push_data_o,
  output logic [ddwce_pkg::TickW-1:0]     idle_ticks_o
);
  import ddwce_pkg::*;

  logic [TickW-1:0] idle_q, idle_d, idle_inc;
  logic             accept, is_tick;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (kind_e'(s_axis_tuser) == KIND_TICK);
  assign idle_inc      = (idle_q == {TickW{1'b1}}) ? idle_q : idle_q + TickW'(1);

  always_comb begin
    idle_d = idle_q;
    if (accept) begin
      idle_d = is_tick ? idle_inc : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= '0;
    end else begin
      idle_q <= idle_d;
    end
  end

  // a tick only makes a job once the counter is past the timeout
  assign push_o           = accept && (!is_tick || (idle_inc > timeout_ticks_i));
  assign push_data_o.stop = is_tick;
  assign push_data_o.lin  = s_axis_tdata[23:0];
  assign push_data_o.ang  = s_axis_tdata[47:24];
  assign idle_ticks_o     = idle_q;

endmodule

`default_nettype wire

// File: hw/rtl/ddwce_back.sv
// Back end: kinematics on one shared 24x24 multiplier, digit encoding and
// the eight-character output shift register. Depends on ddwce_pkg.
`default_nettype none

module ddwce_back #(
  parameter int unsigned FractionBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddwce_pkg::cfg_t    cfg_i,
  input  ddwce_pkg::entry_t  head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // command_byte, zero padded
  output logic               m_axis_tlast   // last_byte
);
  import ddwce_pkg::*;

  localparam logic [47:0] TurnMask  = (48'(1) << FractionBits) - 48'(1);
  localparam logic [71:0] WheelMask = (72'(1) << FractionBits) - 72'(1);
  localparam int unsigned LevelShift = 2 * FractionBits;

  back_state_e state_q, state_d;

  logic signed [SpeedW-1:0] v_q, w_q;
  logic [MulW-1:0]          mul_a, mul_b;
  logic [2*MulW-1:0]        prod_q;
  logic signed [48:0]       turn_q;
  logic [47:0]              lmag_q, rmag_q;
  logic                     lneg_q, rneg_q;
  logic                     wheel_q;
  logic [47:0]              acc_lo_q;
  logic [71:0]              acc_q;
  logic [LimW-1:0]          magc_q;
  logic                     dneg_q;
  logic [CharW-1:0]         chars_q [NumChars];
  logic [2:0]               cnt_q;

  logic [47:0]        cur_mag;
  logic               cur_neg;
  logic [47:0]        w_abs, tmag;
  logic signed [49:0] v_ext, t_ext, lsum, rsum, labs, rabs;
  logic [71:0]        fq, fm;
  logic [47:0]        lvl_full;
  logic [4:0]         level, tens, ones;
  logic               out_hs;

  function automatic logic signed [SpeedW-1:0] clamp_sym(logic signed [SpeedW-1:0] x,
                                                         logic [LimW-1:0] lim);
    logic signed [SpeedW-1:0] l;
    l = $signed({1'b0, lim});
    if (x > l) begin
      return l;
    end else if (x < -l) begin
      return -l;
    end
    return x;
  endfunction

  assign out_hs  = m_axis_tvalid && m_axis_tready;
  assign cur_mag = wheel_q ? rmag_q : lmag_q;
  assign cur_neg = wheel_q ? rneg_q : lneg_q;

  // next state and control
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = head_i.stop ? B_EMIT : B_TURN;
        end
      end
      B_TURN:       state_d = B_TURN_FLOOR;
      B_TURN_FLOOR: state_d = B_SUM;
      B_SUM:        state_d = B_MUL_LO;
      B_MUL_LO:     state_d = B_MUL_HI;
      B_MUL_HI:     state_d = B_ACC;
      B_ACC:        state_d = B_CLAMP;
      B_CLAMP:      state_d = B_LEVEL;
      B_LEVEL:      state_d = B_DIGITS;
      B_DIGITS:     state_d = wheel_q ? B_EMIT : B_MUL_LO;
      B_EMIT: begin
        if (out_hs && (cnt_q == 3'd7)) state_d = B_IDLE;
      end
      default:      state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // shared multiplier operands
  assign w_abs = w_q[SpeedW-1] ? 48'(-w_q) : 48'(w_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      B_TURN: begin
        mul_a = w_abs[MulW-1:0];
        mul_b = {1'b0, cfg_i.half_track};
      end
      B_MUL_LO: begin
        mul_a = cur_mag[23:0];
        mul_b = cfg_i.inv_radius;
      end
      B_MUL_HI: begin
        mul_a = cur_mag[47:24];
        mul_b = cfg_i.inv_radius;
      end
      B_LEVEL: begin
        mul_a = {1'b0, magc_q};
        mul_b = {1'b0, cfg_i.level_gain};
      end
      default: ;
    endcase
  end

  // turn term: floor of w*half_track, sign-magnitude
  assign tmag = (prod_q >> FractionBits)
              + 48'(w_q[SpeedW-1] && ((prod_q & TurnMask) != '0));

  // wheel sums and their magnitudes
  assign v_ext = 50'(v_q);
  assign t_ext = 50'(turn_q);
  assign lsum  = v_ext - t_ext;
  assign rsum  = v_ext + t_ext;
  assign labs  = lsum[49] ? -lsum : lsum;
  assign rabs  = rsum[49] ? -rsum : rsum;

  // wheel speed floor: negative values round away from zero in magnitude
  assign fq = acc_q >> FractionBits;
  assign fm = fq + 72'(cur_neg && ((acc_q & WheelMask) != '0));

  // level digits
  assign lvl_full = prod_q >> LevelShift;
  assign level    = (lvl_full > 48'(LevelCap)) ? LevelCap : lvl_full[4:0];
  always_comb begin
    if (level >= 5'd20) begin
      tens = 5'd2;
    end else if (level >= 5'd10) begin
      tens = 5'd1;
    end else begin
      tens = 5'd0;
    end
    ones = level - 5'(tens * 5'd10);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      B_IDLE: begin
        v_q <= clamp_sym(head_i.lin, cfg_i.linear_limit);
        w_q <= clamp_sym(head_i.ang, cfg_i.angular_limit);
        if (!empty_i && head_i.stop) begin
          for (int i = 0; i < NumChars; i++) chars_q[i] <= CharZero;
        end
      end
      B_TURN_FLOOR: turn_q <= w_q[SpeedW-1] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      B_SUM: begin
        lmag_q <= labs[47:0];
        lneg_q <= lsum[49];
        rmag_q <= rabs[47:0];
        rneg_q <= rsum[49];
      end
      B_MUL_HI: acc_lo_q <= prod_q;
      B_ACC:    acc_q    <= {24'b0, acc_lo_q} + {prod_q, 24'b0};
      B_CLAMP: begin
        if (fm > 72'(cfg_i.wheel_speed_cap)) begin
          magc_q <= cfg_i.wheel_speed_cap;
          dneg_q <= cur_neg && (cfg_i.wheel_speed_cap != '0);
        end else begin
          magc_q <= fm[LimW-1:0];
          dneg_q <= cur_neg && (fm != '0);
        end
      end
      B_DIGITS: begin
        chars_q[{wheel_q, 2'd0}] <= CharZero;
        chars_q[{wheel_q, 2'd1}] <= dneg_q ? CharRev : CharFwd;
        chars_q[{wheel_q, 2'd2}] <= CharZero + CharW'(tens);
        chars_q[{wheel_q, 2'd3}] <= CharZero + CharW'(ones);
      end
      B_EMIT: begin
        if (out_hs) begin
          for (int i = 0; i < NumChars - 1; i++) chars_q[i] <= chars_q[i+1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (state_q == B_IDLE) begin
        wheel_q <= 1'b0;
        cnt_q   <= '0;
      end else if (state_q == B_DIGITS) begin
        wheel_q <= 1'b1;
      end else if (out_hs) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  assign m_axis_tvalid = (state_q == B_EMIT);
  assign m_axis_tdata  = {2'b00, chars_q[0]};
  assign m_axis_tlast  = (cnt_q == 3'd7);

endmodule

`default_nettype wire

// File: hw/rtl/diff_drive_wheel_command_encoder.sv
// Top level of the differential-drive wheel command encoder: register file,
// front end, job queue and back end. Depends on ddwce_pkg, ddwce_front,
// ddwce_queue and ddwce_back.
//
//  channel   direction  transaction                 payload
//  s_axis    in         velocity command or tick    tdata {ang[47:24], lin[23:0]}, tuser kind
//  m_axis    out        one ASCII digit             tdata[5:0] char, tlast on 8th char
//  cfg       in         register write, no wait     cfg_idx_i, cfg_data_i
//
// A velocity command runs its arithmetic on the single shared 24x24
// multiplier (turn term, two partial products and a level product per wheel),
// then sends its eight characters. A stop string only sends its characters.
// Ticks that do not take the idle count past the timeout produce no job.
// The front keeps taking transactions while the back works, up to two
// queued jobs. Reset restores register defaults and clears the idle count.
`default_nettype none

module diff_drive_wheel_command_encoder #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,  // linear_velocity, angular_velocity
  input  logic                               s_axis_tuser,  // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // command_byte
  output logic                               m_axis_tlast,  // last_byte
  input  logic                               cfg_we_i,
  input  logic [ddwce_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ddwce_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ddwce_pkg::*;

  cfg_t             cfg_q;
  entry_t           push_data, head;
  q_status_t        q_status;
  logic             push, pop;
  logic [TickW-1:0] idle_ticks;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_limit    <= LinearLimitRst;
      cfg_q.angular_limit   <= AngularLimitRst;
      cfg_q.half_track      <= HalfTrackRst;
      cfg_q.inv_radius      <= InvRadiusRst;
      cfg_q.wheel_speed_cap <= WheelSpeedCapRst;
      cfg_q.level_gain      <= LevelGainRst;
      cfg_q.timeout_ticks   <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINEAR_LIMIT:    cfg_q.linear_limit    <= cfg_data_i[LimW-1:0];
        CFG_ANGULAR_LIMIT:   cfg_q.angular_limit   <= cfg_data_i[LimW-1:0];
        CFG_HALF_TRACK:      cfg_q.half_track      <= cfg_data_i[LimW-1:0];
        CFG_INV_RADIUS:      cfg_q.inv_radius      <= cfg_data_i[GainW-1:0];
        CFG_WHEEL_SPEED_CAP: cfg_q.wheel_speed_cap <= cfg_data_i[LimW-1:0];
        CFG_LEVEL_GAIN:      cfg_q.level_gain      <= cfg_data_i[LimW-1:0];
        CFG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  ddwce_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .timeout_ticks_i (cfg_q.timeout_ticks),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_data_o     (push_data),
    .idle_ticks_o    (idle_ticks)
  );

  ddwce_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  ddwce_back #(
    .FractionBits (FRACTION_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg_q),
    .head_i   (head),
    .empty_i  (q_status.empty),
    .pop_o    (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  // A velocity command always clears the idle count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (idle_ticks == '0))
    else $error("idle count not cleared by velocity command");

  // Every character sent is an ASCII digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57)))
    else $error("non-digit character on output");

  // After the eighth character the back end goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output continued past the last character");

  // The input is held off exactly when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !q_status.full)
    else $error("input ready out of step with queue fill");

endmodule

`default_nettype wire

// File: tb/wheel_command_checker.sv
// Checker for the wheel command encoder. It mirrors register writes, predicts
// the eight ASCII digits of each command or stop string and compares them in order.
// Depends on ddwce_pkg.
`timescale 1ns / 1ps

module wheel_command_checker
  import ddwce_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // linear_velocity, angular_velocity
  input  logic                s_axis_tuser,  // kind
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [7:0]          m_axis_tdata,  // command_byte
  input  logic                m_axis_tlast,  // last_byte
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  mismatches_o
);

  localparam logic [TickW-1:0] IdleMax = '1;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] digit;
    logic       is_last;
  } wheel_char_t;

  cfg_t             regs;
  logic [TickW-1:0] idle_ticks;
  wheel_char_t      wheel_chars_q [$];
  wheel_char_t      want;
  int               mismatches;
  logic [CharW-1:0] stop_chars [NumChars];

  function automatic longint clamp_mag(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic void push_chars(input logic [CharW-1:0] chars [NumChars]);
    for (int i = 0; i < NumChars; i++) begin
      wheel_chars_q.push_back('{digit: 8'(chars[i]), is_last: (i == NumChars - 1)});
    end
  endfunction

  // Inverse kinematics, wheel clamp and digit encoding, left wheel first.
  function automatic void predict_velocity(input logic signed [SpeedW-1:0] lin,
                                           input logic signed [SpeedW-1:0] ang);
    longint           v;
    longint           w;
    longint           turn;
    longint           mag;
    longint           lvl;
    longint           wheel [2];
    logic [CharW-1:0] chars [NumChars];
    v = clamp_mag(longint'(lin), longint'(regs.linear_limit));
    w = clamp_mag(longint'(ang), longint'(regs.angular_limit));
    turn = (w * longint'(regs.half_track)) >>> FRACTION_BITS;
    wheel[0] = ((v - turn) * longint'(regs.inv_radius)) >>> FRACTION_BITS;
    wheel[1] = ((v + turn) * longint'(regs.inv_radius)) >>> FRACTION_BITS;
    for (int k = 0; k < 2; k++) begin
      wheel[k] = clamp_mag(wheel[k], longint'(regs.wheel_speed_cap));
      mag = (wheel[k] < 0) ? -wheel[k] : wheel[k];
      lvl = (mag * longint'(regs.level_gain)) >>> (2 * FRACTION_BITS);
      if (lvl > LevelCap) lvl = LevelCap;
      chars[4*k]     = CharZero;
      chars[4*k + 1] = (wheel[k] < 0) ? CharRev : CharFwd;
      chars[4*k + 2] = CharZero + CharW'(lvl / 10);
      chars[4*k + 3] = CharZero + CharW'(lvl % 10);
    end
    push_chars(chars);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{linear_limit:    LinearLimitRst,
               angular_limit:   AngularLimitRst,
               half_track:      HalfTrackRst,
               inv_radius:      InvRadiusRst,
               wheel_speed_cap: WheelSpeedCapRst,
               level_gain:      LevelGainRst,
               timeout_ticks:   TimeoutTicksRst};
      idle_ticks = '0;
      wheel_chars_q.delete();
      mismatches = 0;
      foreach (stop_chars[i]) stop_chars[i] = CharZero;
      pending_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINEAR_LIMIT:    regs.linear_limit    = cfg_data_i[LimW-1:0];
          CFG_ANGULAR_LIMIT:   regs.angular_limit   = cfg_data_i[LimW-1:0];
          CFG_HALF_TRACK:      regs.half_track      = cfg_data_i[LimW-1:0];
          CFG_INV_RADIUS:      regs.inv_radius      = cfg_data_i[GainW-1:0];
          CFG_WHEEL_SPEED_CAP: regs.wheel_speed_cap = cfg_data_i[LimW-1:0];
          CFG_LEVEL_GAIN:      regs.level_gain      = cfg_data_i[LimW-1:0];
          CFG_TIMEOUT_TICKS:   regs.timeout_ticks   = cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_TICK) begin
          if (idle_ticks != IdleMax) idle_ticks++;
          if (idle_ticks > regs.timeout_ticks) push_chars(stop_chars);
        end else begin
          idle_ticks = '0;
          predict_velocity(s_axis_tdata[23:0], s_axis_tdata[47:24]);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (wheel_chars_q.size() == 0) begin
          if (mismatches < ReportLimit)
            $display("%0t: unexpected output byte 0x%02h last %0b",
                     $time, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = wheel_chars_q.pop_front();
          if (m_axis_tdata !== want.digit || m_axis_tlast !== want.is_last) begin
            if (mismatches < ReportLimit)
              $display("%0t: output byte mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                       $time, want.digit, want.is_last, m_axis_tdata, m_axis_tlast);
            mismatches++;
          end
        end
      end

      pending_o <= wheel_chars_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// File: tb/diff_drive_wheel_command_encoder_tb.sv
// Top of the wheel command encoder testbench: clock, reset, stimulus, register
// setup and verdict. Depends on ddwce_pkg, wheel_command_checker and the RTL.
`timescale 1ns / 1ps

module diff_drive_wheel_command_encoder_tb;
  import ddwce_pkg::*;

  localparam int unsigned FractionBits = 16;
  localparam int unsigned IdlePercent  = 26;
  // Give a tick that makes no output time to settle after the longest velocity job
  localparam int unsigned SettleCycles = 48;
  // Cycles without any accepted transaction before the run is declared hung
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned NumRegs      = 7;
  // Index past the register list: the block must ignore writes to it
  localparam logic [CfgIdxW-1:0]  CfgIdxUnused = 3'd7;
  localparam logic [CfgDataW-1:0] AllOnes      = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata;  // linear_velocity, angular_velocity
  logic                s_axis_tuser;  // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // command_byte
  logic                m_axis_tlast;  // last_byte
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int                  pending;
  int                  mismatches;
  int unsigned         stall_cycles = 0;
  logic                no_gaps = 1'b0;

  // Register values for the next phase, and the limits the stimulus aims around
  logic [CfgDataW-1:0] phase_regs [NumRegs];
  int unsigned         cur_lin_lim;
  int unsigned         cur_ang_lim;

  always #6 clk_i = ~clk_i;

  diff_drive_wheel_command_encoder #(
    .FRACTION_BITS(FractionBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  wheel_command_checker #(
    .FRACTION_BITS(FractionBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // Output side back-pressure: random stalls, none while no_gaps is set
  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Hang detector: any accepted transaction on either stream resets the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("diff_drive_wheel_command_encoder verification failed");
      $finish;
    end
  end

  // One input transaction, with random gaps in front of it unless no_gaps is set.
  // Called right after a rising edge; returns at the edge that accepted it.
  task automatic push_item(input kind_e kind, input logic [SpeedW-1:0] lin,
                           input logic [SpeedW-1:0] ang);
    while (!no_gaps && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {ang, lin};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending, wait for every predicted byte, then let the back end go quiet
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes every register of phase_regs, plus one write to the unused index
  task automatic apply_regs();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LINEAR_LIMIT;
    cfg_data_i <= phase_regs[CFG_LINEAR_LIMIT];
    @(posedge clk_i);
    cfg_idx_i <= CFG_ANGULAR_LIMIT;
    cfg_data_i <= phase_regs[CFG_ANGULAR_LIMIT];
    @(posedge clk_i);
    cfg_idx_i <= CFG_HALF_TRACK;
    cfg_data_i <= phase_regs[CFG_HALF_TRACK];
    @(posedge clk_i);
    cfg_idx_i <= CFG_INV_RADIUS;
    cfg_data_i <= phase_regs[CFG_INV_RADIUS];
    @(posedge clk_i);
    cfg_idx_i <= CFG_WHEEL_SPEED_CAP;
    cfg_data_i <= phase_regs[CFG_WHEEL_SPEED_CAP];
    @(posedge clk_i);
    cfg_idx_i <= CFG_LEVEL_GAIN;
    cfg_data_i <= phase_regs[CFG_LEVEL_GAIN];
    @(posedge clk_i);
    cfg_idx_i <= CFG_TIMEOUT_TICKS;
    cfg_data_i <= phase_regs[CFG_TIMEOUT_TICKS];
    @(posedge clk_i);
    cfg_idx_i <= CfgIdxUnused;
    cfg_data_i <= CfgDataW'($urandom());
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_lin_lim = 32'(phase_regs[CFG_LINEAR_LIMIT][LimW-1:0]);
    cur_ang_lim = 32'(phase_regs[CFG_ANGULAR_LIMIT][LimW-1:0]);
  endtask

  function automatic void set_default_regs(input logic [TickW-1:0] timeout);
    phase_regs[CFG_LINEAR_LIMIT]    = CfgDataW'(LinearLimitRst);
    phase_regs[CFG_ANGULAR_LIMIT]   = CfgDataW'(AngularLimitRst);
    phase_regs[CFG_HALF_TRACK]      = CfgDataW'(HalfTrackRst);
    phase_regs[CFG_INV_RADIUS]      = CfgDataW'(InvRadiusRst);
    phase_regs[CFG_WHEEL_SPEED_CAP] = CfgDataW'(WheelSpeedCapRst);
    phase_regs[CFG_LEVEL_GAIN]      = CfgDataW'(LevelGainRst);
    phase_regs[CFG_TIMEOUT_TICKS]   = CfgDataW'(timeout);
  endfunction

  function automatic void fill_regs(input logic [CfgDataW-1:0] value);
    foreach (phase_regs[i]) phase_regs[i] = value;
  endfunction

  // Random geometry; the gain is kept near 25 / max speed so levels spread out.
  // Bits above each register's width are random to exercise the masking.
  function automatic void set_random_regs();
    longint unsigned top_speed;
    longint unsigned gain;
    top_speed = 64'($urandom_range(65536, 8388607));
    gain = ((64'(LevelCap) << (2 * FractionBits)) / top_speed)
           * 64'($urandom_range(90, 115)) / 64'(100);
    phase_regs[CFG_LINEAR_LIMIT]    = {1'($urandom()), LimW'($urandom_range(0, 1 << 20))};
    phase_regs[CFG_ANGULAR_LIMIT]   = {1'($urandom()), LimW'($urandom_range(0, 1 << 19))};
    phase_regs[CFG_HALF_TRACK]      = {1'($urandom()), LimW'($urandom_range(0, 1 << 17))};
    phase_regs[CFG_INV_RADIUS]      = GainW'($urandom_range(1 << 15, 1 << 22));
    phase_regs[CFG_WHEEL_SPEED_CAP] = {1'($urandom()), LimW'(top_speed)};
    phase_regs[CFG_LEVEL_GAIN]      = {1'($urandom()), LimW'(gain)};
    phase_regs[CFG_TIMEOUT_TICKS]   = {16'($urandom()), TickW'($urandom_range(0, 4))};
  endfunction

  // Half full-range, half close to the clamp limit so both paths are hit
  function automatic logic [SpeedW-1:0] pick_speed(input int unsigned lim);
    int span;
    int offset;
    if ($urandom_range(0, 1) == 0) return SpeedW'($urandom());
    span = int'(lim + lim / 4 + 2);
    offset = int'($urandom_range(0, 2 * span)) - span;
    return SpeedW'(offset);
  endfunction

  // Mostly velocity commands; tick runs of up to eight so short timeouts expire
  task automatic run_random(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        run_len = $urandom_range(1, 8);
        repeat (run_len) push_item(KIND_TICK, SpeedW'($urandom()), SpeedW'($urandom()));
        sent += run_len;
      end else begin
        push_item(KIND_VELOCITY, pick_speed(cur_lin_lim), pick_speed(cur_ang_lim));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_VELOCITY;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LINEAR_LIMIT;
    cfg_data_i    = '0;
    cur_lin_lim   = 32'(LinearLimitRst);
    cur_ang_lim   = 32'(AngularLimitRst);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: field extremes, exact limits, zero speed ("01"),
    // tiny negative speed that floors to level zero but still reads "02"
    push_item(KIND_VELOCITY, 24'h000000, 24'h000000);
    push_item(KIND_VELOCITY, 24'h7FFFFF, 24'h000000);
    push_item(KIND_VELOCITY, 24'h800000, 24'h000000);
    push_item(KIND_VELOCITY, 24'h000000, 24'h7FFFFF);
    push_item(KIND_VELOCITY, 24'h000000, 24'h800000);
    push_item(KIND_VELOCITY, 24'h7FFFFF, 24'h7FFFFF);
    push_item(KIND_VELOCITY, 24'h800000, 24'h800000);
    push_item(KIND_VELOCITY, 24'hFFFFFF, 24'h000000);
    push_item(KIND_VELOCITY, 24'h000001, 24'h000000);
    push_item(KIND_VELOCITY, 24'h003333, 24'h000000);
    push_item(KIND_VELOCITY, 24'hFFCCCD, 24'h018000);
    push_item(KIND_VELOCITY, 24'h000000, 24'hFE7FFF);
    push_item(KIND_TICK, 24'hFFFFFF, 24'hFFFFFF);
    drain_results();

    // Zero timeout: every tick sends the stop string
    set_default_regs('0);
    apply_regs();
    push_item(KIND_TICK, 24'h000000, 24'h000000);
    push_item(KIND_TICK, 24'h7FFFFF, 24'h800000);
    push_item(KIND_VELOCITY, 24'h7FFFFF, 24'h800000);
    push_item(KIND_TICK, 24'h000000, 24'h000000);
    push_item(KIND_VELOCITY, 24'h000000, 24'h000000);
    push_item(KIND_TICK, 24'h800000, 24'h7FFFFF);
    drain_results();

    set_default_regs(TickW'(3));
    apply_regs();
    run_random(30);
    drain_results();

    // Zero limits and gains: every wheel encodes as forward, level zero
    fill_regs('0);
    apply_regs();
    run_random(15);
    drain_results();

    // Random geometry; the middle phase runs with no gaps on either side
    for (int r = 0; r < 3; r++) begin
      set_random_regs();
      apply_regs();
      no_gaps <= (r == 1);
      run_random(30);
      drain_results();
      no_gaps <= 1'b0;
    end

    // Long tick run: the idle count saturates, timeout 254 still expires
    set_default_regs(TickW'(254));
    apply_regs();
    repeat (262) push_item(KIND_TICK, SpeedW'($urandom()), SpeedW'($urandom()));
    drain_results();

    // All ones, masked to each width: timeout 255 never expires even when saturated
    fill_regs(AllOnes);
    apply_regs();
    repeat (3) push_item(KIND_TICK, SpeedW'($urandom()), SpeedW'($urandom()));
    run_random(15);
    drain_results();

    if (mismatches == 0) begin
      $display("diff_drive_wheel_command_encoder verification clean");
    end else begin
      $display("diff_drive_wheel_command_encoder verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ddwce_pkg.sv
hw/rtl/ddwce_queue.sv
hw/rtl/ddwce_front.sv
hw/rtl/ddwce_back.sv
hw/rtl/diff_drive_wheel_command_encoder.sv
tb/wheel_command_checker.sv
tb/diff_drive_wheel_command_encoder_tb.sv
